/* rtl/ssim_window_integer_accumulate_top_defines.svh */
// assertion macros for the window ssim accumulator
`ifndef SSIM_WINDOW_INTEGER_ACCUMULATE_TOP_DEFINES_SVH
`define SSIM_WINDOW_INTEGER_ACCUMULATE_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SWIA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swia check failed");

// antecedent implies consequent in the next cycle
`define SWIA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swia check failed");

`endif

/* rtl/swia_pkg.sv */
// shared types and constants of the window ssim accumulator
package swia_pkg;

  localparam int SCALE_LOG2_DEF  = 10;
  localparam int MAX_WINDOWS_DEF = 1048576;

  localparam int SUM_W   = 14;
  localparam int SQ_W    = 22;
  localparam int TOT_W   = 64;
  localparam int COUNT_W = 21;
  localparam int WS_W    = 4;
  localparam int CST_W   = 30;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;
  localparam int DIV_CNT_W  = 6;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C1          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C2          = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_W2, ST_M, ST_RR, ST_CC, ST_VR, ST_VC, ST_VX, ST_ABCD,
    ST_NUM, ST_DEN, ST_DINIT, ST_DIV, ST_DFIX,
    ST_SQ0A, ST_SQ1A, ST_SQ0B, ST_SQ1B, ST_ACC
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_W2, OP_M, OP_RR, OP_CC, OP_VR, OP_VC, OP_VX,
    OP_ABCD, OP_NUM, OP_DEN, OP_DINIT, OP_DSTEP, OP_DFIX,
    OP_SQ0, OP_SQ1, OP_ACC
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_block;
  } status_t;

endpackage

/* rtl/swia_ctrl.sv */
// sequencer for the window ssim datapath
module swia_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  swia_pkg::status_t status,
  output swia_pkg::cmd_t    cmd,
  output logic              busy
);
  import swia_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_W2;
      ST_W2:    state_nxt = ST_M;
      ST_M:     state_nxt = ST_RR;
      ST_RR:    state_nxt = ST_CC;
      ST_CC:    state_nxt = ST_VR;
      ST_VR:    state_nxt = ST_VC;
      ST_VC:    state_nxt = ST_VX;
      ST_VX:    state_nxt = ST_ABCD;
      ST_ABCD:  state_nxt = ST_NUM;
      ST_NUM:   state_nxt = ST_DEN;
      ST_DEN:   state_nxt = ST_DINIT;
      ST_DINIT: state_nxt = ST_DIV;
      ST_DIV:   if (status.div_last) state_nxt = ST_DFIX;
      ST_DFIX:  state_nxt = ST_SQ0A;
      ST_SQ0A:  state_nxt = ST_SQ1A;
      ST_SQ1A:  state_nxt = ST_SQ0B;
      ST_SQ0B:  state_nxt = ST_SQ1B;
      ST_SQ1B:  state_nxt = ST_ACC;
      ST_ACC:   if (!status.out_block) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    busy   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        cmd.op = OP_LOAD;
        busy   = 1'b0;
      end
      ST_W2:    cmd.op = OP_W2;
      ST_M:     cmd.op = OP_M;
      ST_RR:    cmd.op = OP_RR;
      ST_CC:    cmd.op = OP_CC;
      ST_VR:    cmd.op = OP_VR;
      ST_VC:    cmd.op = OP_VC;
      ST_VX:    cmd.op = OP_VX;
      ST_ABCD:  cmd.op = OP_ABCD;
      ST_NUM:   cmd.op = OP_NUM;
      ST_DEN:   cmd.op = OP_DEN;
      ST_DINIT: cmd.op = OP_DINIT;
      ST_DIV:   cmd.op = OP_DSTEP;
      ST_DFIX:  cmd.op = OP_DFIX;
      ST_SQ0A, ST_SQ0B: cmd.op = OP_SQ0;
      ST_SQ1A, ST_SQ1B: cmd.op = OP_SQ1;
      ST_ACC:   cmd.op = status.out_block ? OP_NONE : OP_ACC;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

/* rtl/swia_dp.sv */
// datapath: shared multiplier, restoring divider, accumulators, result register
module swia_dp #(
  parameter int SCALE_LOG2  = swia_pkg::SCALE_LOG2_DEF,
  parameter int MAX_WINDOWS = swia_pkg::MAX_WINDOWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swia_pkg::cmd_t                      cmd,
  output swia_pkg::status_t                   status,
  input  logic                                cfg_we,
  input  logic [swia_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swia_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic [swia_pkg::SUM_W-1:0]          in_ref_sum,
  input  logic [swia_pkg::SUM_W-1:0]          in_cmp_sum,
  input  logic [swia_pkg::SQ_W-1:0]           in_ref_square_sum,
  input  logic [swia_pkg::SQ_W-1:0]           in_cmp_square_sum,
  input  logic [swia_pkg::SQ_W-1:0]           in_cross_sum,
  input  logic                                in_last_window,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [swia_pkg::TOT_W-1:0]   out_ssim_total,
  output logic signed [swia_pkg::TOT_W-1:0]   out_ssim_fourth_total,
  output logic [swia_pkg::COUNT_W-1:0]        out_window_count
);
  import swia_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOWS);

  logic [WS_W-1:0]  ws_r;
  logic [CST_W-1:0] c1_r, c2_r;

  logic [SUM_W-1:0] sr_r, sc_r;
  logic [SQ_W-1:0]  qr_r, qc_r, qx_r;
  logic             last_r;

  logic [7:0]  w2_r;
  logic [31:0] m_r, rr_r, cc_r, pr_r, pc_r, px_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic signed [63:0] num_r, den_r;
  logic [64:0] rem_r;
  logic [63:0] quo_r, mag_d_r;
  logic        neg_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [63:0] val_r, x_r, sq_r;

  logic [63:0] acc_s_r, acc_q_r;
  logic [CNT_W-1:0] cnt_r;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_s_r, out_q_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic [31:0] hc1, hc2, qc2, vr, vc;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic signed [63:0] dvd, dvs, den_half;
  logic [64:0] trial;
  logic [63:0] acc_s_nxt, acc_q_nxt;
  logic [CNT_W-1:0] cnt_nxt;

  // operand selection for the single shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_W2:  begin mul_a = 33'(ws_r);  mul_b = 33'(ws_r); end
      OP_M:   begin mul_a = 33'(sr_r);  mul_b = 33'(sc_r); end
      OP_RR:  begin mul_a = 33'(sr_r);  mul_b = 33'(sr_r); end
      OP_CC:  begin mul_a = 33'(sc_r);  mul_b = 33'(sc_r); end
      OP_VR:  begin mul_a = 33'(qr_r);  mul_b = 33'(w2_r); end
      OP_VC:  begin mul_a = 33'(qc_r);  mul_b = 33'(w2_r); end
      OP_VX:  begin mul_a = 33'(qx_r);  mul_b = 33'(w2_r); end
      OP_NUM: begin mul_a = {a_r[31], a_r}; mul_b = {b_r[31], b_r}; end
      OP_DEN: begin mul_a = {c_r[31], c_r}; mul_b = {d_r[31], d_r}; end
      OP_SQ0: begin mul_a = {1'b0, x_r[31:0]}; mul_b = {1'b0, x_r[31:0]}; end
      OP_SQ1: begin mul_a = {1'b0, x_r[31:0]}; mul_b = {1'b0, x_r[63:32]}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign hc1 = 32'(c1_r >> 1);
  assign hc2 = 32'(c2_r >> 1);
  assign qc2 = 32'(c2_r >> 2);
  assign vr  = pr_r - rr_r;
  assign vc  = pc_r - cc_r;
  assign a_nxt = m_r + hc1;
  assign b_nxt = (px_r >> 1) - (m_r >> 1) + qc2;
  assign c_nxt = (rr_r >> 1) + (cc_r >> 1) + hc1;
  assign d_nxt = (vr >> 1) + (vc >> 1) + hc2;

  // den / 2 truncating toward zero
  assign den_half = (den_r + $signed({63'd0, den_r[63]})) >>> 1;
  assign dvd = num_r + den_half;
  assign dvs = den_r | 64'sd1;

  assign trial = {rem_r[63:0], quo_r[63]} - {1'b0, mag_d_r};

  assign acc_s_nxt = acc_s_r + val_r;
  assign acc_q_nxt = acc_q_r + x_r;
  assign cnt_nxt   = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;

  // result valid: cleared on transfer, set when a run closes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.op == OP_ACC && last_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WS_W'(8);
      c1_r <= '0;
      c2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SIZE: ws_r <= cfg_data[WS_W-1:0];
        REG_C1:          c1_r <= cfg_data[CST_W-1:0];
        REG_C2:          c2_r <= cfg_data[CST_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: if (in_valid) begin
        sr_r   <= in_ref_sum;
        sc_r   <= in_cmp_sum;
        qr_r   <= in_ref_square_sum;
        qc_r   <= in_cmp_square_sum;
        qx_r   <= in_cross_sum;
        last_r <= in_last_window;
      end
      OP_W2:   w2_r <= prod[7:0];
      OP_M:    m_r  <= prod[31:0];
      OP_RR:   rr_r <= prod[31:0];
      OP_CC:   cc_r <= prod[31:0];
      OP_VR:   pr_r <= prod[31:0];
      OP_VC:   pc_r <= prod[31:0];
      OP_VX:   px_r <= prod[31:0];
      OP_ABCD: begin
        a_r <= a_nxt;
        b_r <= b_nxt;
        c_r <= c_nxt;
        d_r <= d_nxt;
      end
      OP_NUM:  num_r <= prod[63:0];
      OP_DEN:  den_r <= $signed(prod[63:0]) >>> (SCALE_LOG2 + 1);
      OP_DINIT: begin
        rem_r     <= '0;
        quo_r     <= dvd[63] ? 64'(-dvd) : 64'(dvd);
        mag_d_r   <= dvs[63] ? 64'(-dvs) : 64'(dvs);
        neg_r     <= dvd[63] ^ dvs[63];
        div_cnt_r <= '0;
      end
      OP_DSTEP: begin
        if (!trial[64]) begin
          rem_r <= trial;
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[63:0], quo_r[63]};
          quo_r <= {quo_r[62:0], 1'b0};
        end
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      OP_DFIX: begin
        val_r <= neg_r ? -quo_r : quo_r;
        x_r   <= neg_r ? -quo_r : quo_r;
      end
      OP_SQ0:  sq_r <= prod[63:0];
      // square mod 2^64: lo*lo + 2*(lo*hi) << 32
      OP_SQ1:  x_r <= sq_r + {prod[30:0], 33'd0};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_s_r     <= '0;
      acc_q_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.op == OP_ACC) begin
        if (last_r) begin
          acc_s_r <= '0;
          acc_q_r <= '0;
          cnt_r   <= '0;
        end else begin
          acc_s_r <= acc_s_nxt;
          acc_q_r <= acc_q_nxt;
          cnt_r   <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACC && last_r) begin
      out_s_r   <= acc_s_nxt;
      out_q_r   <= acc_q_nxt;
      out_cnt_r <= cnt_nxt;
    end
  end

  assign status.div_last  = (div_cnt_r == DIV_CNT_W'(63));
  assign status.out_block = last_r && out_valid_r && !out_ready;

  assign out_valid             = out_valid_r;
  assign out_ssim_total        = out_s_r;
  assign out_ssim_fourth_total = out_q_r;
  assign out_window_count      = COUNT_W'(out_cnt_r);

endmodule

/* rtl/ssim_window_integer_accumulate_top.sv */
// top level of the window integer ssim accumulator, 8x8 windows after reset
// no new window is taken until the last one has passed the 64-step restoring divider, thirteen
//   passes of the shared multiplier and five other steps; the final step waits on a held result
// reset: synchronous active-low; clears sequencer, accumulators and result valid,
//   window_size returns to 8 and both constants to zero
module ssim_window_integer_accumulate_top #(
  parameter int SCALE_LOG2  = swia_pkg::SCALE_LOG2_DEF,
  parameter int MAX_WINDOWS = swia_pkg::MAX_WINDOWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [swia_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swia_pkg::CFG_DATA_W-1:0]     cfg_data,
  // window statistics in
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [swia_pkg::SUM_W-1:0]          in_ref_sum,
  input  logic [swia_pkg::SUM_W-1:0]          in_cmp_sum,
  input  logic [swia_pkg::SQ_W-1:0]           in_ref_square_sum,
  input  logic [swia_pkg::SQ_W-1:0]           in_cmp_square_sum,
  input  logic [swia_pkg::SQ_W-1:0]           in_cross_sum,
  input  logic                                in_last_window,
  // totals out
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [swia_pkg::TOT_W-1:0]   out_ssim_total,
  output logic signed [swia_pkg::TOT_W-1:0]   out_ssim_fourth_total,
  output logic [swia_pkg::COUNT_W-1:0]        out_window_count
);
  import swia_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    busy;

  // a window is taken only while the sequencer sits idle; the result register
  // holds a pending total so the next run can start meanwhile
  assign in_ready = !busy;

  swia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  swia_dp #(
    .SCALE_LOG2  (SCALE_LOG2),
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ref_sum            (in_ref_sum),
    .in_cmp_sum            (in_cmp_sum),
    .in_ref_square_sum     (in_ref_square_sum),
    .in_cmp_square_sum     (in_cmp_square_sum),
    .in_cross_sum          (in_cross_sum),
    .in_last_window        (in_last_window),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_ssim_total        (out_ssim_total),
    .out_ssim_fourth_total (out_ssim_fourth_total),
    .out_window_count      (out_window_count)
  );

endmodule

/* rtl/swia_chk.sv */
// port-level checks for the window ssim accumulator
`include "ssim_window_integer_accumulate_top_defines.svh"

module swia_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [swia_pkg::TOT_W-1:0]   out_ssim_total,
  input logic [swia_pkg::COUNT_W-1:0]        out_window_count
);

  `SWIA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_ssim_total))
  `SWIA_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `SWIA_ASSERT_NOW(a_count_nonzero, out_valid, out_window_count != '0)
  `SWIA_ASSERT_NOW(a_result_needs_work, $rose(out_valid), $past(!in_ready))

endmodule

bind ssim_window_integer_accumulate_top swia_chk u_swia_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_ssim_total   (out_ssim_total),
  .out_window_count (out_window_count)
);

/* test/ssim_window_integer_accumulate_checker.sv */
// checker for the window ssim accumulator: predicts the totals and compares each result transfer
`timescale 1ns / 1ps

module ssim_window_integer_accumulate_checker #(
  parameter int SCALE_LOG2  = swia_pkg::SCALE_LOG2_DEF,
  parameter int MAX_WINDOWS = swia_pkg::MAX_WINDOWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [swia_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swia_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [swia_pkg::SUM_W-1:0]          in_ref_sum,
  input  logic [swia_pkg::SUM_W-1:0]          in_cmp_sum,
  input  logic [swia_pkg::SQ_W-1:0]           in_ref_square_sum,
  input  logic [swia_pkg::SQ_W-1:0]           in_cmp_square_sum,
  input  logic [swia_pkg::SQ_W-1:0]           in_cross_sum,
  input  logic                                in_last_window,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [swia_pkg::TOT_W-1:0]   out_ssim_total,
  input  logic signed [swia_pkg::TOT_W-1:0]   out_ssim_fourth_total,
  input  logic [swia_pkg::COUNT_W-1:0]        out_window_count,
  output int                                  fail_count,
  output int                                  totals_pending,
  output int                                  totals_checked
);
  import swia_pkg::*;

  typedef struct {
    logic [TOT_W-1:0]   score_sum;
    logic [TOT_W-1:0]   fourth_sum;
    logic [COUNT_W-1:0] windows;
  } run_totals_t;

  run_totals_t        totals_q[$];
  logic [WS_W-1:0]    side_len;
  logic [CST_W-1:0]   c1_val;
  logic [CST_W-1:0]   c2_val;
  logic [TOT_W-1:0]   score_sum;
  logic [TOT_W-1:0]   fourth_sum;
  logic [COUNT_W-1:0] windows;

  // integer ssim of one window, every 32-bit step wrapping
  function automatic longint window_ssim(
    logic [SUM_W-1:0] sr, logic [SUM_W-1:0] sc,
    logic [SQ_W-1:0] qr, logic [SQ_W-1:0] qc, logic [SQ_W-1:0] qx);
    logic [31:0] w2, m, rr, cc, vr, vc, vx, a, b, c, d;
    longint num, den;
    w2 = {28'd0, side_len} * {28'd0, side_len};
    m  = {18'd0, sr} * {18'd0, sc};
    rr = {18'd0, sr} * {18'd0, sr};
    cc = {18'd0, sc} * {18'd0, sc};
    vr = {10'd0, qr} * w2 - rr;
    vc = {10'd0, qc} * w2 - cc;
    vx = {10'd0, qx} * w2;
    a  = m + {2'd0, c1_val} / 32'd2;
    b  = (vx >> 1) - (m >> 1) + {2'd0, c2_val} / 32'd4;
    c  = (rr >> 1) + (cc >> 1) + {2'd0, c1_val} / 32'd2;
    d  = (vr >> 1) + (vc >> 1) + {2'd0, c2_val} / 32'd2;
    num = longint'(int'(a)) * longint'(int'(b));
    den = (longint'(int'(c)) * longint'(int'(d))) >>> (SCALE_LOG2 + 1);
    return (num + den / 2) / (den | 64'sd1);
  endfunction

  always @(posedge clk) begin
    logic [63:0]  q;
    run_totals_t  got, want;
    if (!rst_n) begin
      side_len   <= 4'd8;
      c1_val     <= '0;
      c2_val     <= '0;
      score_sum  <= '0;
      fourth_sum <= '0;
      windows    <= '0;
      fail_count <= 0;
      totals_checked <= 0;
      totals_pending <= 0;
      totals_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_SIZE: side_len <= cfg_data[WS_W-1:0];
          REG_C1:          c1_val   <= cfg_data[CST_W-1:0];
          REG_C2:          c2_val   <= cfg_data[CST_W-1:0];
          default: ;  // unused index, ignored
        endcase
      end
      if (in_valid && in_ready) begin
        q = window_ssim(in_ref_sum, in_cmp_sum, in_ref_square_sum,
                        in_cmp_square_sum, in_cross_sum);
        want.score_sum  = score_sum + q;
        want.fourth_sum = fourth_sum + q * q * q * q;
        want.windows    = (int'(windows) < MAX_WINDOWS) ? windows + 1'b1 : windows;
        if (in_last_window) begin
          totals_q.push_back(want);
          score_sum  <= '0;
          fourth_sum <= '0;
          windows    <= '0;
        end else begin
          score_sum  <= want.score_sum;
          fourth_sum <= want.fourth_sum;
          windows    <= want.windows;
        end
      end
      if (out_valid && out_ready) begin
        totals_checked <= totals_checked + 1;
        if (totals_q.size() == 0) begin
          $error("totals transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = totals_q.pop_front();
          got.score_sum  = out_ssim_total;
          got.fourth_sum = out_ssim_fourth_total;
          got.windows    = out_window_count;
          if (got.score_sum !== want.score_sum ||
              got.fourth_sum !== want.fourth_sum ||
              got.windows !== want.windows)
            fail_count <= fail_count + 1;
          if (got.score_sum !== want.score_sum)
            $error("ssim_total expected %0d got %0d",
                   $signed(want.score_sum), $signed(got.score_sum));
          if (got.fourth_sum !== want.fourth_sum)
            $error("ssim_fourth_total expected %0d got %0d",
                   $signed(want.fourth_sum), $signed(got.fourth_sum));
          if (got.windows !== want.windows)
            $error("window_count expected %0d got %0d", want.windows, got.windows);
        end
      end
      totals_pending <= totals_q.size();
    end
  end

endmodule

/* test/ssim_window_integer_accumulate_top_test.sv */
// testbench top for the window ssim accumulator: stimulus, flow control and verdict
`timescale 1ns / 1ps

module ssim_window_integer_accumulate_top_test;
  import swia_pkg::*;

  localparam int RUN_LIMIT = 600000;  // cycles, far above the slowest correct run
  localparam int DRAIN_GAP = 100;     // wait after the totals drain, longer than the result latency
  localparam int LONG_HOLD = 700;     // receiver hold-off, several windows' worth

  // index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SUM_W-1:0] in_ref_sum = '0;
  logic [SUM_W-1:0] in_cmp_sum = '0;
  logic [SQ_W-1:0]  in_ref_square_sum = '0;
  logic [SQ_W-1:0]  in_cmp_square_sum = '0;
  logic [SQ_W-1:0]  in_cross_sum = '0;
  logic in_last_window = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [TOT_W-1:0] out_ssim_total;
  logic signed [TOT_W-1:0] out_ssim_fourth_total;
  logic [COUNT_W-1:0] out_window_count;

  int fail_count, totals_pending, totals_checked;
  int send_idle_pct = 0;   // chance of a sender gap before a transfer
  int recv_idle_pct = 0;   // chance per cycle of out_ready low
  bit long_hold_req = 1'b0;
  int cycles = 0;
  int windows_sent = 0;

  always #1 clk = ~clk;

  ssim_window_integer_accumulate_top i_dut (.*);

  ssim_window_integer_accumulate_checker i_checker (.*);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request so the block backs up
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one window transfer, sometimes with a random gap beforehand
  task automatic send_window(logic [SUM_W-1:0] sr, logic [SUM_W-1:0] sc,
                             logic [SQ_W-1:0] qr, logic [SQ_W-1:0] qc,
                             logic [SQ_W-1:0] qx, logic last);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_ref_sum        <= sr;
    in_cmp_sum        <= sc;
    in_ref_square_sum <= qr;
    in_cmp_square_sum <= qc;
    in_cross_sum      <= qx;
    in_last_window    <= last;
    // ready is sampled mid-cycle, clear of the edge
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    windows_sent++;
  endtask

  // mostly plausible 8x8 statistics, some raw full-width noise
  task automatic send_random_window(logic last);
    logic [SUM_W-1:0] sr, sc;
    logic [SQ_W-1:0]  qr, qc, qx;
    int unsigned spread;
    if ($urandom_range(3) == 0) begin
      sr = SUM_W'($urandom);
      sc = SUM_W'($urandom);
      qr = SQ_W'($urandom);
      qc = SQ_W'($urandom);
      qx = SQ_W'($urandom);
    end else begin
      sr = SUM_W'($urandom_range(16320));
      sc = (sr > 2000 && $urandom_range(1) != 0) ?
           SUM_W'(int'(sr) - int'($urandom_range(2000))) : SUM_W'($urandom_range(16320));
      spread = $urandom_range(400000);
      qr = SQ_W'((int'(sr) * int'(sr)) / 64 + int'($urandom_range(spread)));
      qc = SQ_W'((int'(sc) * int'(sc)) / 64 + int'($urandom_range(spread)));
      qx = SQ_W'((int'(sr) * int'(sc)) / 64 + int'($urandom_range(spread)));
    end
    send_window(sr, sc, qr, qc, qx, last);
  endtask

  task automatic send_frames(int n_windows);
    int left, len;
    left = n_windows;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) send_random_window(i == len - 1);
      left -= len;
    end
  endtask

  // let every expected total drain, plus the block's latency, before a register write
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    wait (totals_pending == 0);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed windows at reset settings: extremes, single-window runs, equal images
    send_idle_pct = 28; recv_idle_pct = 51;
    send_window('0, '0, '0, '0, '0, 1'b1);
    send_window('1, '1, '1, '1, '1, 1'b1);
    send_window(14'd16320, 14'd16320, 22'd4161600, 22'd4161600, 22'd4161600, 1'b0);
    send_window(14'd16320, 14'd0, 22'd4161600, 22'd0, 22'd0, 1'b0);
    send_window(14'd0, 14'd16320, 22'd0, 22'd4161600, 22'd0, 1'b1);
    send_window(14'd8160, 14'd8160, 22'd1040400, 22'd1040400, 22'd1040400, 1'b1);
    send_window(14'h2aaa, 14'h1555, 22'h2aaaaa, 22'h155555, 22'h3fffff, 1'b0);
    send_window(14'h1555, 14'h2aaa, 22'h155555, 22'h2aaaaa, 22'h000001, 1'b1);
    settle();

    // window size zero, an out-of-range side, the unused index and large constants
    cfg_write(REG_WINDOW_SIZE, 30'd0);
    cfg_write(REG_UNUSED, '1);
    send_window(14'd100, 14'd200, 22'd5000, 22'd9000, 22'd7000, 1'b1);
    settle();
    cfg_write(REG_WINDOW_SIZE, 30'd15);
    cfg_write(REG_C1, '1);
    cfg_write(REG_C2, '1);
    send_window('1, '1, '1, '1, '1, 1'b0);
    send_window('0, '0, '0, '0, '0, 1'b1);
    send_window(14'd16320, 14'd1, 22'd4161600, 22'd1, 22'd127, 1'b1);
    settle();
    cfg_write(REG_WINDOW_SIZE, 30'd1);
    cfg_write(REG_C1, 30'd1);
    cfg_write(REG_C2, 30'd3);
    send_window(14'd64, 14'd64, 22'd64, 22'd64, 22'd64, 1'b1);
    send_window(14'd255, 14'd0, 22'd65025, 22'd0, 22'd0, 1'b1);
    settle();

    // random phases through a range of settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 28; recv_idle_pct = 51; end
        2: begin send_idle_pct = 51; recv_idle_pct = 28; end
        4: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        default: ;
      endcase
      case (ph)
        0: begin
          cfg_write(REG_WINDOW_SIZE, 30'd8);
          cfg_write(REG_C1, 30'd26634);   // (0.01*255)^2 * 4096
          cfg_write(REG_C2, 30'd239708);  // (0.03*255)^2 * 4096
        end
        1: begin
          cfg_write(REG_C1, 30'd0);
          cfg_write(REG_C2, 30'd0);
        end
        2: cfg_write(REG_WINDOW_SIZE, CFG_DATA_W'($urandom_range(1, 7)));
        3: begin
          cfg_write(REG_WINDOW_SIZE, 30'd8);
          cfg_write(REG_C1, CFG_DATA_W'($urandom));
          cfg_write(REG_C2, CFG_DATA_W'($urandom));
        end
        4: begin
          cfg_write(REG_WINDOW_SIZE, CFG_DATA_W'($urandom_range(15)));
          cfg_write(REG_C1, CFG_DATA_W'($urandom_range(100000)));
          cfg_write(REG_C2, CFG_DATA_W'($urandom_range(1000000)));
        end
        default: begin
          cfg_write(REG_WINDOW_SIZE, 30'd8);
          cfg_write(REG_C1, 30'd26634);
          cfg_write(REG_C2, 30'd239708);
        end
      endcase
      if (ph == 5) begin
        // hold the result side while single-window runs keep coming
        long_hold_req = 1'b1;
        for (int i = 0; i < 20; i++) send_random_window(1'b1);
      end
      send_frames(ph == 5 ? 120 : 140);
      settle();
    end

    $display("run covered %0d windows and %0d totals over several register settings",
             windows_sent, totals_checked);
    $display("including window size 0 and 15, constants at both ends and a long result stall");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* ssim_window_integer_accumulate_top.f */
+incdir+rtl
rtl/swia_pkg.sv
rtl/swia_ctrl.sv
rtl/swia_dp.sv
rtl/ssim_window_integer_accumulate_top.sv
rtl/swia_chk.sv
test/ssim_window_integer_accumulate_checker.sv
test/ssim_window_integer_accumulate_top_test.sv
